// File: hdl/bhbh_pkg.sv
// shared types, constants and handshake structs for the binary hash block histogram
// no dependencies; imported by bhbh_dp, bhbh_ctrl and the top module
package bhbh_pkg;

    // default geometry
    localparam int DEF_IMG_DIM      = 28;
    localparam int DEF_BLOCK_DIM    = 7;
    localparam int DEF_BLOCK_STEP   = 4;
    localparam int DEF_FILTER_COUNT = 8;
    localparam int DEF_BIN_COUNT    = 256;

    // field widths
    localparam int RESP_W     = 16;
    localparam int RESP_COUNT = 8;
    localparam int CODE_W     = 8;
    localparam int COUNT_W    = 6;
    localparam int BLKSEL_W   = 6;
    localparam int BINSEL_W   = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // stream layout
    localparam int S_TUSER_W   = 2;
    localparam int BLKSEL_LSB  = RESP_COUNT * RESP_W;
    localparam int BINSEL_LSB  = BLKSEL_LSB + BLKSEL_W;
    localparam int S_TDATA_W   = 144;
    localparam int M_TDATA_W   = 8;

    typedef enum logic [S_TUSER_W-1:0] {
        ACT_PIXEL = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // controller to datapath
    typedef struct packed {
        logic take;        // input transaction accepted
        logic clr_step;    // write zero at the sweep address
        logic inc_step;    // read one histogram entry of the current pixel
        logic rd_issue;    // read the entry of a read item
        logic rd_capture;  // hold the read data
        logic out_load;    // move the held count to the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic iter_live;
        logic iter_last;
        logic out_free;
    } status_t;

endpackage

// File: hdl/bhbh_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module bhbh_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 9216
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/bhbh_span.sv
// scan position along one image axis and the range of blocks that cover it
// depends on nothing but its parameters
module bhbh_span #(
    parameter int IMG_DIM    = 28,
    parameter int BLOCK_DIM  = 7,
    parameter int BLOCK_STEP = 4,
    parameter int NBLK       = 6,
    parameter int BLK_W      = 3,
    parameter int ADDR_W     = 14,
    parameter int LO_STRIDE  = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              restart,
    input  logic              advance,
    output logic              wrap,
    output logic [BLK_W-1:0]  lo,
    output logic [BLK_W-1:0]  hi,
    output logic [ADDR_W-1:0] lo_base,
    output logic              live
);

    localparam int POS_W = $clog2(IMG_DIM);
    localparam int END_W = $clog2(IMG_DIM + BLOCK_DIM + BLOCK_STEP + 1);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BLK_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [END_W-1:0]  lo_end_reg, lo_end_next;      // first position past block lo
    logic [END_W-1:0]  nx_start_reg, nx_start_next;  // first position of block hi+1
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [END_W-1:0]  pos_inc;

    always_comb begin
        pos_inc       = END_W'(pos_reg) + END_W'(1);
        wrap          = advance && (pos_reg == POS_W'(IMG_DIM - 1));
        pos_next      = pos_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        lo_end_next   = lo_end_reg;
        nx_start_next = nx_start_reg;
        base_next     = base_reg;
        if (restart || wrap) begin
            pos_next      = '0;
            lo_next       = '0;
            hi_next       = '0;
            lo_end_next   = END_W'(BLOCK_DIM);
            nx_start_next = END_W'(BLOCK_STEP);
            base_next     = '0;
        end else if (advance) begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_inc == lo_end_reg) begin
                lo_next     = lo_reg + BLK_W'(1);
                lo_end_next = lo_end_reg + END_W'(BLOCK_STEP);
                base_next   = base_reg + ADDR_W'(LO_STRIDE);
            end
            if ((pos_inc == nx_start_reg) && ((int'(hi_reg) + 1) < NBLK)) begin
                hi_next       = hi_reg + BLK_W'(1);
                nx_start_next = nx_start_reg + END_W'(BLOCK_STEP);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            lo_end_reg   <= END_W'(BLOCK_DIM);
            nx_start_reg <= END_W'(BLOCK_STEP);
            base_reg     <= '0;
        end else begin
            pos_reg      <= pos_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            lo_end_reg   <= lo_end_next;
            nx_start_reg <= nx_start_next;
            base_reg     <= base_next;
        end
    end

    assign lo      = lo_reg;
    assign hi      = hi_reg;
    assign lo_base = base_reg;
    assign live    = (NBLK > 0) && (lo_reg <= hi_reg);

endmodule

// File: hdl/bhbh_dp.sv
// datapath: hash code, scan trackers, block iteration, histogram ram and output register
// depends on bhbh_pkg, bhbh_span and bhbh_ram
module bhbh_dp #(
    parameter int IMG_DIM      = 28,
    parameter int BLOCK_DIM    = 7,
    parameter int BLOCK_STEP   = 4,
    parameter int FILTER_COUNT = 8,
    parameter int BIN_COUNT    = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bhbh_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [bhbh_pkg::S_TUSER_W-1:0] s_tuser,
    input  bhbh_pkg::cmd_t                cmd,
    output bhbh_pkg::status_t             status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bhbh_pkg::M_TDATA_W-1:0] m_tdata
);

    import bhbh_pkg::*;

    localparam int NBLK        = (IMG_DIM >= BLOCK_DIM) ?
                                 ((IMG_DIM - BLOCK_DIM) / BLOCK_STEP + 1) : 0;
    localparam int STORE_DEPTH = (NBLK > 0) ? NBLK * NBLK * BIN_COUNT : 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BLK_W       = (NBLK > 0) ? $clog2(NBLK + 1) : 1;
    localparam int CB_STRIDE   = NBLK * BIN_COUNT;
    localparam int CODE_XW     = CODE_W + 1;

    logic                take_pix, take_rd, take_clr;
    logic [CODE_W-1:0]   code;
    logic                code_ok;
    logic                col_wrap, col_live, row_live;
    logic [BLK_W-1:0]    col_lo, col_hi, row_lo, row_hi;
    logic [ADDR_W-1:0]   col_base, row_base;
    logic [BLKSEL_W-1:0] blk_sel;
    logic [BINSEL_W-1:0] bin_sel;

    // block iteration for one pixel
    logic [ADDR_W-1:0]   addr_reg, addr_next, cb_base_reg, cb_base_next;
    logic [BLK_W-1:0]    cb_reg, cb_next, cb_hi_reg, cb_hi_next;
    logic [BLK_W-1:0]    rb_reg, rb_next, rb_lo_reg, rb_lo_next, rb_hi_reg, rb_hi_next;
    logic                live_reg, live_next;

    // read item, increment write-back, clearing sweep
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic                rd_ok_reg;
    logic [COUNT_W-1:0]  rd_val_reg;
    logic                wr_pend_reg;
    logic [ADDR_W-1:0]   wr_addr_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic                m_tvalid_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [COUNT_W-1:0]  ram_wdata, ram_rdata;

    assign take_pix = cmd.take && (action_t'(s_tuser) == ACT_PIXEL);
    assign take_rd  = cmd.take && (action_t'(s_tuser) == ACT_READ);
    assign take_clr = cmd.take && (action_t'(s_tuser) == ACT_CLEAR);
    assign blk_sel  = s_tdata[BLKSEL_LSB +: BLKSEL_W];
    assign bin_sel  = s_tdata[BINSEL_LSB +: BINSEL_W];

    // a strictly positive response sets its bit, first filter in the msb
    always_comb begin
        logic signed [RESP_W-1:0] resp;
        code = '0;
        for (int f = 0; f < RESP_COUNT; f++) begin
            resp = s_tdata[f*RESP_W +: RESP_W];
            if ((f < FILTER_COUNT) && (resp > 0)) begin
                code[CODE_W-1-f] = 1'b1;
            end
        end
    end

    assign code_ok = {1'b0, code} < CODE_XW'(BIN_COUNT);

    bhbh_span #(
        .IMG_DIM   (IMG_DIM),
        .BLOCK_DIM (BLOCK_DIM),
        .BLOCK_STEP(BLOCK_STEP),
        .NBLK      (NBLK),
        .BLK_W     (BLK_W),
        .ADDR_W    (ADDR_W),
        .LO_STRIDE (CB_STRIDE)
    ) u_col (
        .aclk   (aclk),
        .aresetn(aresetn),
        .restart(take_clr),
        .advance(take_pix),
        .wrap   (col_wrap),
        .lo     (col_lo),
        .hi     (col_hi),
        .lo_base(col_base),
        .live   (col_live)
    );

    bhbh_span #(
        .IMG_DIM   (IMG_DIM),
        .BLOCK_DIM (BLOCK_DIM),
        .BLOCK_STEP(BLOCK_STEP),
        .NBLK      (NBLK),
        .BLK_W     (BLK_W),
        .ADDR_W    (ADDR_W),
        .LO_STRIDE (BIN_COUNT)
    ) u_row (
        .aclk   (aclk),
        .aresetn(aresetn),
        .restart(take_clr),
        .advance(col_wrap),
        .wrap   (),
        .lo     (row_lo),
        .hi     (row_hi),
        .lo_base(row_base),
        .live   (row_live)
    );

    // row block inner, column block outer; addresses step by constants only
    always_comb begin
        addr_next    = addr_reg;
        cb_base_next = cb_base_reg;
        cb_next      = cb_reg;
        cb_hi_next   = cb_hi_reg;
        rb_next      = rb_reg;
        rb_lo_next   = rb_lo_reg;
        rb_hi_next   = rb_hi_reg;
        live_next    = live_reg;
        if (take_pix) begin
            addr_next    = col_base + row_base + ADDR_W'(code);
            cb_base_next = col_base + row_base + ADDR_W'(code);
            cb_next      = col_lo;
            cb_hi_next   = col_hi;
            rb_next      = row_lo;
            rb_lo_next   = row_lo;
            rb_hi_next   = row_hi;
            live_next    = col_live && row_live && code_ok;
        end else if (cmd.inc_step) begin
            if (rb_reg == rb_hi_reg) begin
                rb_next      = rb_lo_reg;
                cb_next      = cb_reg + BLK_W'(1);
                cb_base_next = cb_base_reg + ADDR_W'(CB_STRIDE);
                addr_next    = cb_base_reg + ADDR_W'(CB_STRIDE);
            end else begin
                rb_next   = rb_reg + BLK_W'(1);
                addr_next = addr_reg + ADDR_W'(BIN_COUNT);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg     <= 1'b0;
            wr_pend_reg  <= 1'b0;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            live_reg    <= live_next;
            wr_pend_reg <= cmd.inc_step && live_reg;
            if (take_clr) begin
                clr_addr_reg <= '0;
            end else if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        cb_base_reg <= cb_base_next;
        cb_reg      <= cb_next;
        cb_hi_reg   <= cb_hi_next;
        rb_reg      <= rb_next;
        rb_lo_reg   <= rb_lo_next;
        rb_hi_reg   <= rb_hi_next;
        wr_addr_reg <= addr_reg;
        if (take_rd) begin
            rd_addr_reg <= ADDR_W'(blk_sel) * ADDR_W'(BIN_COUNT) + ADDR_W'(bin_sel);
            rd_ok_reg   <= (int'(blk_sel) < NBLK * NBLK) && (int'(bin_sel) < BIN_COUNT);
        end
        if (cmd.rd_capture) begin
            rd_val_reg <= rd_ok_reg ? ram_rdata : '0;
        end
        if (cmd.out_load) begin
            m_count_reg <= rd_val_reg;
        end
    end

    // sweep writes zeros; otherwise write back the saturated increment
    always_comb begin
        ram_raddr = cmd.rd_issue ? rd_addr_reg : addr_reg;
        if (cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = wr_pend_reg;
            ram_waddr = wr_addr_reg;
            ram_wdata = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_W'(1);
        end
    end

    bhbh_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign status.clr_done  = (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1));
    assign status.iter_live = live_reg;
    assign status.iter_last = (cb_reg == cb_hi_reg) && (rb_reg == rb_hi_reg);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - COUNT_W){1'b0}}, m_count_reg};

    a_wr_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr_step && wr_pend_reg))
        else $error("clearing sweep and increment write in the same cycle");

    a_iter_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.inc_step && live_reg) |->
            (cb_reg <= cb_hi_reg && rb_reg >= rb_lo_reg && rb_reg <= rb_hi_reg))
        else $error("block iteration left the covering range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !cmd.out_load)
        else $error("pending result overwritten");

endmodule

// File: hdl/bhbh_ctrl.sv
// controller: sequences clearing sweep, per-pixel increments and read items
// depends on bhbh_pkg
module bhbh_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bhbh_pkg::S_TUSER_W-1:0] s_tuser,
    input  bhbh_pkg::status_t             status,
    output bhbh_pkg::cmd_t                cmd
);

    import bhbh_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_INC     = 6'b000100,
        ST_RD_ADDR = 6'b001000,
        ST_RD_DATA = 6'b010000,
        ST_RD_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    unique case (action_t'(s_tuser))
                        ACT_PIXEL: state_next = ST_INC;
                        ACT_READ:  state_next = ST_RD_ADDR;
                        ACT_CLEAR: state_next = ST_CLEAR;
                        ACT_NONE:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INC: begin
                cmd.inc_step = 1'b1;
                if (!status.iter_live || status.iter_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_ADDR: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/binary_hash_block_histogram_top.sv
// Binary hash block histogram. Pixels of one IMG_DIM x IMG_DIM map arrive in raster order on the
// s_ stream, kind in s_tuser (0 pixel, 1 read one bin count, 2 clear, 3 ignored). A pixel's
// eight filter responses form an 8-bit code (a strictly positive response sets its bit, first
// filter weighted 128); the code is counted, saturating at 63, into the histogram of every
// BLOCK_DIM x BLOCK_DIM block at stride BLOCK_STEP that covers the pixel. Blocks are numbered
// column-start block times the blocks per axis plus row-start block. A read returns one
// count on the m_ stream, zero for a block or bin out of range. Sequencing: after acceptance
// a pixel walks its covering blocks in turn (0, 1, 2 or 4 covering blocks with the defaults,
// none in the last row and column), each costing one read-modify-write on the single histogram
// ram; a read issues its address, captures the data and then loads the result into the output
// register once that is free, and the block is free again once the result is loaded; a clear
// and the start after reset both sweep the whole store, one entry a cycle (9216 entries with
// the defaults), during which s_tready is low.
// depends on bhbh_pkg, bhbh_ctrl and bhbh_dp
module binary_hash_block_histogram_top #(
    parameter int IMG_DIM      = bhbh_pkg::DEF_IMG_DIM,
    parameter int BLOCK_DIM    = bhbh_pkg::DEF_BLOCK_DIM,
    parameter int BLOCK_STEP   = bhbh_pkg::DEF_BLOCK_STEP,
    parameter int FILTER_COUNT = bhbh_pkg::DEF_FILTER_COUNT,
    parameter int BIN_COUNT    = bhbh_pkg::DEF_BIN_COUNT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // resp_a [15:0], resp_b, resp_c, resp_d, resp_e, resp_f, resp_g, resp_h [127:112],
    // block_sel [133:128], bin_sel [141:134], zero fill [143:142]
    input  logic [bhbh_pkg::S_TDATA_W-1:0] s_tdata,
    // action [1:0]
    input  logic [bhbh_pkg::S_TUSER_W-1:0] s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // bin_count [5:0], zero fill [7:6]
    output logic [bhbh_pkg::M_TDATA_W-1:0] m_tdata
);

    import bhbh_pkg::*;

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: clearing sweep, per-pixel block walk, read transaction
    bhbh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: hashing, scan position, histogram ram and output register
    bhbh_dp #(
        .IMG_DIM     (IMG_DIM),
        .BLOCK_DIM   (BLOCK_DIM),
        .BLOCK_STEP  (BLOCK_STEP),
        .FILTER_COUNT(FILTER_COUNT),
        .BIN_COUNT   (BIN_COUNT)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .status  (status),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule
